[rtl/core/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256 package
// types and constants shared by the sha-256 byte stream hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [5:0] PAD_LEN_POS = 6'd56;

    typedef logic [31:0] word_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t v;
        v = 32'h0;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic word_t round_const(input logic [5:0] t);
        word_t k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[t];
    endfunction

    function automatic word_t rotr(input word_t v, input int unsigned k);
        return (v >> k) | (v << (32 - k));
    endfunction

endpackage

[rtl/core/sha256_stream_if.sv]
// ----------------------------------------------------------------------------
// sha256 stream interface
// valid/ready channel carrying one payload struct
// ----------------------------------------------------------------------------
interface sha256_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/sha256_byte_stream_hasher.sv]
// sha-256 over a byte stream
// absorb: one byte per cycle; a full block then holds input off during
// (block word loads, hash word reads, compression rounds, hash add-writes)
// finish: padding one byte a cycle, one or two compressions, then 8 output
// transfers and a reload of the initial values
// reset: asynchronous, hash memory reloaded with initial values by an init pass
// ----------------------------------------------------------------------------
// sha256 byte stream hasher
// block byte memory and hash word memory with a shared round unit
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic  clk,
    input  logic  rst_n,
    sha256_stream_if.sink   in_ch,
    sha256_stream_if.source out_ch
);
    import sha256_pkg::*;

    typedef enum logic [8:0] {
        ST_INIT  = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_PAD   = 9'b000000100,
        ST_LOAD  = 9'b000001000,
        ST_HRD   = 9'b000010000,
        ST_ROUND = 9'b000100000,
        ST_ADD   = 9'b001000000,
        ST_OUT   = 9'b010000000,
        ST_OWAIT = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] msg_reg, msg_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic        fin_reg, fin_next;
    logic [1:0]  padph_reg, padph_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        ovalid_reg;
    out_item_t   oitem_reg;

    word_t       blk_mem [16];
    word_t       hash_mem [8];
    word_t       blk_q;
    word_t       hash_q;

    logic        bwr_en;
    logic [5:0]  bwr_addr;
    logic [7:0]  bwr_data;
    logic [3:0]  brd_word;
    logic        hwr_en;
    logic [2:0]  hwr_addr;
    word_t       hwr_data;
    logic [2:0]  hrd_addr;

    logic        ld_valid_reg;
    logic [3:0]  ld_idx_reg;
    logic        h_valid_reg;
    logic [2:0]  h_idx_reg;
    word_t       hsnap_reg [8];

    word_t       w_cur;
    word_t       vars [8];
    logic        sched_shift;
    logic        rnd_init;
    logic        rnd_step;

    logic        in_fire;
    logic        out_fire;
    logic [7:0]  pad_byte;

    assign in_fire  = in_ch.valid & in_ch.ready;
    assign out_fire = out_ch.valid & out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload = oitem_reg;

    // big-endian byte lanes within each block word
    always_ff @(posedge clk)
    begin
        if (bwr_en)
        begin
            blk_mem[bwr_addr[5:2]][{~bwr_addr[1:0], 3'b000} +: 8] <= bwr_data;
        end
        blk_q <= blk_mem[brd_word];
    end

    always_ff @(posedge clk)
    begin
        if (hwr_en)
        begin
            hash_mem[hwr_addr] <= hwr_data;
        end
        hash_q <= hash_mem[hrd_addr];
    end

    always_ff @(posedge clk)
    begin
        ld_idx_reg <= cnt_reg[3:0];
        h_idx_reg  <= cnt_reg[2:0];
        if (h_valid_reg && state_reg == ST_HRD)
        begin
            hsnap_reg[h_idx_reg] <= hash_q;
        end
    end

    sha256_sched u_sched (
        .clk       (clk),
        .load      (ld_valid_reg),
        .load_idx  (ld_idx_reg),
        .load_word (blk_q),
        .shift     (sched_shift),
        .w_out     (w_cur)
    );

    sha256_round u_round (
        .clk       (clk),
        .init      (rnd_init),
        .init_vals (hsnap_reg),
        .step      (rnd_step),
        .round_idx (rnd_reg),
        .w_in      (w_cur),
        .vars      (vars)
    );

    always_comb
    begin
        pad_byte = 8'h00;
        if (padph_reg == 2'd0)
        begin
            pad_byte = 8'h80;
        end
        else if (padph_reg == 2'd2)
        begin
            pad_byte = bitlen_reg[63:56];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        msg_next    = msg_reg;
        bitlen_next = bitlen_reg;
        fin_next    = fin_reg;
        padph_next  = padph_reg;
        cnt_next    = cnt_reg;
        rnd_next    = rnd_reg;
        bwr_en      = 1'b0;
        bwr_addr    = fill_reg;
        bwr_data    = in_ch.payload.data_byte;
        brd_word    = cnt_reg[3:0];
        hwr_en      = 1'b0;
        hwr_addr    = cnt_reg[2:0];
        hwr_data    = init_hash(cnt_reg[2:0]);
        hrd_addr    = cnt_reg[2:0];
        sched_shift = 1'b0;
        rnd_init    = 1'b0;
        rnd_step    = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                hwr_en = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[2:0] == 3'd7)
                begin
                    cnt_next = 5'd0;
                    fill_next = 6'd0;
                    msg_next = 64'd0;
                    fin_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.payload.action == ACT_ABSORB)
                    begin
                        bwr_en = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        msg_next = msg_reg + 64'd1;
                        if (fill_reg == 6'd63)
                        begin
                            cnt_next = 5'd0;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        bitlen_next = {msg_reg[60:0], 3'b000};
                        fin_next = 1'b1;
                        padph_next = 2'd0;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                bwr_en = 1'b1;
                bwr_data = pad_byte;
                fill_next = fill_reg + 6'd1;
                if (padph_reg == 2'd2)
                begin
                    bitlen_next = {bitlen_reg[55:0], 8'h00};
                end
                if (padph_reg == 2'd0 || padph_reg == 2'd1)
                begin
                    padph_next = (fill_reg + 6'd1 == PAD_LEN_POS) ? 2'd2 : 2'd1;
                end
                if (fill_reg == 6'd63)
                begin
                    cnt_next = 5'd0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    cnt_next = 5'd0;
                    state_next = ST_HRD;
                end
            end
            ST_HRD:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd8)
                begin
                    cnt_next = 5'd0;
                    rnd_next = 6'd0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (cnt_reg == 5'd0)
                begin
                    rnd_init = 1'b1;
                    cnt_next = 5'd1;
                end
                else
                begin
                    rnd_step = 1'b1;
                    sched_shift = 1'b1;
                    rnd_next = rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        cnt_next = 5'd0;
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                hwr_en = 1'b1;
                hwr_data = hsnap_reg[cnt_reg[2:0]] + vars[cnt_reg[2:0]];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[2:0] == 3'd7)
                begin
                    cnt_next = 5'd0;
                    if (!fin_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (fill_reg != 6'd0 || padph_reg != 2'd3)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                hrd_addr = cnt_reg[2:0];
                state_next = ST_OWAIT;
            end
            ST_OWAIT:
            begin
                if (out_fire)
                begin
                    cnt_next = cnt_reg + 5'd1;
                    if (oitem_reg.last_word)
                    begin
                        cnt_next = 5'd0;
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
        if (state_reg == ST_PAD && padph_reg == 2'd2 && fill_reg == 6'd63)
        begin
            padph_next = 2'd3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            fill_reg     <= 6'd0;
            msg_reg      <= 64'd0;
            fin_reg      <= 1'b0;
            padph_reg    <= 2'd0;
            cnt_reg      <= 5'd0;
            rnd_reg      <= 6'd0;
            ld_valid_reg <= 1'b0;
            h_valid_reg  <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            msg_reg      <= msg_next;
            fin_reg      <= fin_next;
            padph_reg    <= padph_next;
            cnt_reg      <= cnt_next;
            rnd_reg      <= rnd_next;
            ld_valid_reg <= (state_reg == ST_LOAD) && (cnt_reg < 5'd16);
            h_valid_reg  <= (state_reg == ST_HRD) && (cnt_reg < 5'd8);
            if (state_reg == ST_OWAIT && !ovalid_reg)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bitlen_reg <= bitlen_next;
        if (state_reg == ST_OWAIT && !ovalid_reg)
        begin
            oitem_reg.digest_word <= hash_q;
        end
        if (state_reg == ST_OUT)
        begin
            oitem_reg.word_index <= cnt_reg[2:0];
            oitem_reg.last_word  <= (cnt_reg[2:0] == 3'd7);
        end
    end

`ifndef SYNTH
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == ST_IDLE)
        else $error("input transfer outside idle");
    a_out_only_owait: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> state_reg == ST_OWAIT)
        else $error("output valid outside output wait");
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && oitem_reg.last_word) |=> state_reg == ST_INIT)
        else $error("hasher not reinitialized after digest");
`endif
endmodule

[rtl/core/sha256_sched.sv]
// ----------------------------------------------------------------------------
// sha256 schedule
// 16-word sliding message schedule window, one word per round
// ----------------------------------------------------------------------------
module sha256_sched (
    input  logic               clk,
    input  logic               load,
    input  logic [3:0]         load_idx,
    input  sha256_pkg::word_t  load_word,
    input  logic               shift,
    output sha256_pkg::word_t  w_out
);
    import sha256_pkg::*;

    word_t win_reg [16];
    word_t s0;
    word_t s1;
    word_t w_new;

    always_comb
    begin
        s0 = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        s1 = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        w_new = win_reg[0] + s0 + win_reg[9] + s1;
    end

    assign w_out = win_reg[0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            win_reg[load_idx] <= load_word;
        end
        else if (shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end
    end
endmodule

[rtl/core/sha256_round.sv]
// ----------------------------------------------------------------------------
// sha256 round
// working variables a..h, one compression round per cycle while step is asserted
// ----------------------------------------------------------------------------
module sha256_round (
    input  logic               clk,
    input  logic               init,
    input  sha256_pkg::word_t  init_vals [8],
    input  logic               step,
    input  logic [5:0]         round_idx,
    input  sha256_pkg::word_t  w_in,
    output sha256_pkg::word_t  vars [8]
);
    import sha256_pkg::*;

    word_t r_reg [8];
    word_t big0;
    word_t big1;
    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    always_comb
    begin
        big1 = rotr(r_reg[4], 6) ^ rotr(r_reg[4], 11) ^ rotr(r_reg[4], 25);
        ch = (r_reg[4] & r_reg[5]) ^ (~r_reg[4] & r_reg[6]);
        t1 = r_reg[7] + big1 + ch + round_const(round_idx) + w_in;
        big0 = rotr(r_reg[0], 2) ^ rotr(r_reg[0], 13) ^ rotr(r_reg[0], 22);
        maj = (r_reg[0] & r_reg[1]) ^ (r_reg[0] & r_reg[2]) ^ (r_reg[1] & r_reg[2]);
        t2 = big0 + maj;
    end

    assign vars = r_reg;

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            r_reg <= init_vals;
        end
        else if (step)
        begin
            r_reg[7] <= r_reg[6];
            r_reg[6] <= r_reg[5];
            r_reg[5] <= r_reg[4];
            r_reg[4] <= r_reg[3] + t1;
            r_reg[3] <= r_reg[2];
            r_reg[2] <= r_reg[1];
            r_reg[1] <= r_reg[0];
            r_reg[0] <= t1 + t2;
        end
    end
endmodule
